// File: rtl/ebed_pkg.sv
`timescale 1ns / 1ps

package ebed_pkg;

	// Field widths.
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned SHORT_W = 16;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned REG_IDX_W = 2;

	// Register indexes, byte address is four times the index.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_DBL_GAP    = 2'd1,
		REG_HOLD       = 2'd2,
		REG_LONG_HOLD  = 2'd3
	} reg_idx_t;

	// Register reset values.
	localparam logic [SHORT_W-1:0] DEBOUNCE_RST  = 16'd20;
	localparam logic [SHORT_W-1:0] DBL_GAP_RST   = 16'd250;
	localparam logic [TIME_W-1:0]  HOLD_RST      = 32'd1000;
	localparam logic [TIME_W-1:0]  LONG_HOLD_RST = 32'd3000;

	// Reset value of the press and release timestamps.
	localparam logic [TIME_W-1:0] STAMP_RST = '1;

	// Rotation codes.
	typedef enum logic [1:0] {
		ROT_NONE = 2'd0,
		ROT_CCW  = 2'd1,
		ROT_CW   = 2'd2
	} rot_t;

	// Button event codes.
	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_SINGLE    = 3'd1,
		EV_DOUBLE    = 3'd2,
		EV_HOLD      = 3'd3,
		EV_LONG_HOLD = 3'd4
	} event_t;

	// Configuration handed from the register file to the detector core.
	typedef struct packed {
		logic [SHORT_W-1:0] debounce_ms;
		logic [SHORT_W-1:0] double_click_gap_ms;
		logic [TIME_W-1:0]  hold_ms;
		logic [TIME_W-1:0]  long_hold_ms;
	} cfg_t;

endpackage

// File: rtl/encoder_and_button_event_detector_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// sample    sample_valid / sample_stall  quadrature_a, quadrature_b, button_level, now_ms
// result    result_valid / result_stall  rotation, button_event
// config    APB write/read, pready = 1   paddr[3:2] selects the register
//
// One item per cycle when the result side does not stall; the path is an input register,
// followed by the detector logic and a result register.
// The detector state advances when an item moves from the input register to the
// result register, so the rate is set by that single state update per cycle.
// Reset clears the detector state, the registers to their defaults and both stages.
// A stalled result holds; the input register still takes an item while it is empty.

module encoder_and_button_event_detector_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Sample channel.
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic                          quadrature_a,
	input  logic                          quadrature_b,
	input  logic                          button_level,
	input  logic [ebed_pkg::TIME_W-1:0]   now_ms,
	// Result channel.
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [1:0]                    rotation,
	output logic [2:0]                    button_event,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ebed_pkg::ADDR_W-1:0]   paddr,
	input  logic [ebed_pkg::DATA_W-1:0]   pwdata,
	output logic [ebed_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	ebed_pkg::cfg_t cfg_q;
	ebed_pkg::reg_idx_t reg_idx;
	logic cfg_wr;

	// Input stage.
	logic                        valid_s1;
	logic                        a_s1;
	logic                        b_s1;
	logic                        level_s1;
	logic [ebed_pkg::TIME_W-1:0] now_s1;

	// Result stage.
	logic              result_valid_q;
	ebed_pkg::rot_t    rotation_q;
	ebed_pkg::event_t  event_q;

	ebed_pkg::rot_t    rot_c;
	ebed_pkg::event_t  event_c;
	logic advance;
	logic step;

	// Register file.
	assign pready  = 1'b1;
	assign reg_idx = ebed_pkg::reg_idx_t'(paddr[ebed_pkg::ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms         <= ebed_pkg::DEBOUNCE_RST;
			cfg_q.double_click_gap_ms <= ebed_pkg::DBL_GAP_RST;
			cfg_q.hold_ms             <= ebed_pkg::HOLD_RST;
			cfg_q.long_hold_ms        <= ebed_pkg::LONG_HOLD_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				ebed_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ms <= pwdata[ebed_pkg::SHORT_W-1:0];
				end
				ebed_pkg::REG_DBL_GAP: begin
					cfg_q.double_click_gap_ms <= pwdata[ebed_pkg::SHORT_W-1:0];
				end
				ebed_pkg::REG_HOLD: begin
					cfg_q.hold_ms <= pwdata[ebed_pkg::TIME_W-1:0];
				end
				ebed_pkg::REG_LONG_HOLD: begin
					cfg_q.long_hold_ms <= pwdata[ebed_pkg::TIME_W-1:0];
				end
			endcase
		end
	end

	// Read back.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ebed_pkg::REG_DEBOUNCE: begin
				prdata = {{(ebed_pkg::DATA_W-ebed_pkg::SHORT_W){1'b0}}, cfg_q.debounce_ms};
			end
			ebed_pkg::REG_DBL_GAP: begin
				prdata = {{(ebed_pkg::DATA_W-ebed_pkg::SHORT_W){1'b0}},
					cfg_q.double_click_gap_ms};
			end
			ebed_pkg::REG_HOLD: begin
				prdata = cfg_q.hold_ms;
			end
			ebed_pkg::REG_LONG_HOLD: begin
				prdata = cfg_q.long_hold_ms;
			end
		endcase
	end

	// The input stage moves on whenever the result register is free or being taken.
	assign advance      = !result_valid_q || !result_stall;
	assign step         = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			a_s1     <= quadrature_a;
			b_s1     <= quadrature_b;
			level_s1 <= button_level;
			now_s1   <= now_ms;
		end
	end

	ebed_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.quadrature_a (a_s1),
		.quadrature_b (b_s1),
		.button_level (level_s1),
		.now_ms       (now_s1),
		.cfg          (cfg_q),
		.rotation     (rot_c),
		.button_event (event_c)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rotation_q <= rot_c;
			event_q    <= event_c;
		end
	end

	assign result_valid = result_valid_q;
	assign rotation     = rotation_q;
	assign button_event = event_q;

endmodule

// File: rtl/ebed_core.sv
`timescale 1ns / 1ps

module ebed_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        quadrature_a,
	input  logic                        quadrature_b,
	input  logic                        button_level,
	input  logic [ebed_pkg::TIME_W-1:0] now_ms,
	input  ebed_pkg::cfg_t              cfg,
	output ebed_pkg::rot_t              rotation,
	output ebed_pkg::event_t            button_event
);

	// Detector state.
	logic                        a_prev_q;
	logic                        btn_prev_q;
	logic [ebed_pkg::TIME_W-1:0] press_time_q;
	logic [ebed_pkg::TIME_W-1:0] release_time_q;
	logic                        ignore_rel_q;
	logic                        single_ok_q;
	logic                        hold_rep_q;
	logic                        long_rep_q;
	logic                        dbl_on_rel_q;
	logic                        dbl_wait_q;

	// Next-state values.
	logic [ebed_pkg::TIME_W-1:0] press_time_d;
	logic [ebed_pkg::TIME_W-1:0] release_time_d;
	logic                        ignore_rel_d;
	logic                        single_ok_d;
	logic                        hold_rep_d;
	logic                        long_rep_d;
	logic                        dbl_on_rel_d;
	logic                        dbl_wait_d;

	// Elapsed times against the stored and the refreshed stamps.
	logic [ebed_pkg::TIME_W-1:0] since_rel;
	logic [ebed_pkg::TIME_W-1:0] since_press;
	logic [ebed_pkg::TIME_W-1:0] since_rel_new;
	logic [ebed_pkg::TIME_W-1:0] since_press_new;
	logic [ebed_pkg::TIME_W-1:0] debounce_ext;
	logic [ebed_pkg::TIME_W-1:0] gap_ext;
	logic                        press_edge;
	logic                        rel_edge;
	logic                        rel_take;

	assign debounce_ext = {{(ebed_pkg::TIME_W-ebed_pkg::SHORT_W){1'b0}}, cfg.debounce_ms};
	assign gap_ext      = {{(ebed_pkg::TIME_W-ebed_pkg::SHORT_W){1'b0}},
		cfg.double_click_gap_ms};

	assign since_rel   = now_ms - release_time_q;
	assign since_press = now_ms - press_time_q;

	// Debounced edges: each is measured from the last accepted opposite edge.
	assign press_edge = !button_level && btn_prev_q && (since_rel > debounce_ext);
	assign rel_edge   = button_level && !btn_prev_q && (since_press > debounce_ext);
	assign rel_take   = rel_edge && !ignore_rel_q;

	// A stamp refreshed on this item reads as zero elapsed time.
	assign since_rel_new   = rel_take ? '0 : since_rel;
	assign since_press_new = press_edge ? '0 : since_press;

	// Rotation step on a rising edge of A, only while the button was released.
	always_comb begin
		rotation = ebed_pkg::ROT_NONE;
		if (!a_prev_q && quadrature_a && btn_prev_q) begin
			rotation = quadrature_b ? ebed_pkg::ROT_CW : ebed_pkg::ROT_CCW;
		end
	end

	// Button event and flag updates, in the order the decisions depend on each other.
	always_comb begin
		button_event   = ebed_pkg::EV_NONE;
		press_time_d   = press_time_q;
		release_time_d = release_time_q;
		ignore_rel_d   = ignore_rel_q;
		single_ok_d    = single_ok_q;
		hold_rep_d     = hold_rep_q;
		long_rep_d     = long_rep_q;
		dbl_on_rel_d   = dbl_on_rel_q;
		dbl_wait_d     = dbl_wait_q;

		if (press_edge) begin
			press_time_d = now_ms;
			ignore_rel_d = 1'b0;
			single_ok_d  = 1'b1;
			hold_rep_d   = 1'b0;
			long_rep_d   = 1'b0;
			dbl_on_rel_d = (since_rel < gap_ext) && !dbl_on_rel_q && dbl_wait_q;
			dbl_wait_d   = 1'b0;
		end else if (rel_take) begin
			release_time_d = now_ms;
			if (!dbl_on_rel_q) begin
				dbl_wait_d = 1'b1;
			end else begin
				button_event = ebed_pkg::EV_DOUBLE;
				dbl_on_rel_d = 1'b0;
				dbl_wait_d   = 1'b0;
				single_ok_d  = 1'b0;
			end
		end

		// A lone click is reported once the double-click gap has run out.
		if (button_level && (since_rel_new >= gap_ext) && dbl_wait_d && !dbl_on_rel_d &&
			single_ok_d && (button_event != ebed_pkg::EV_DOUBLE)) begin
			button_event = ebed_pkg::EV_SINGLE;
			dbl_wait_d   = 1'b0;
		end

		// Hold and long hold while the button stays down.
		if (!button_level && (since_press_new >= cfg.hold_ms)) begin
			if (!hold_rep_d) begin
				button_event = ebed_pkg::EV_HOLD;
				ignore_rel_d = 1'b1;
				dbl_on_rel_d = 1'b0;
				dbl_wait_d   = 1'b0;
				hold_rep_d   = 1'b1;
			end
			if ((since_press_new >= cfg.long_hold_ms) && !long_rep_d) begin
				button_event = ebed_pkg::EV_LONG_HOLD;
				long_rep_d   = 1'b1;
			end
		end
	end

	// State update, once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_prev_q       <= 1'b0;
			btn_prev_q     <= 1'b1;
			press_time_q   <= ebed_pkg::STAMP_RST;
			release_time_q <= ebed_pkg::STAMP_RST;
			ignore_rel_q   <= 1'b0;
			single_ok_q    <= 1'b1;
			hold_rep_q     <= 1'b0;
			long_rep_q     <= 1'b0;
			dbl_on_rel_q   <= 1'b0;
			dbl_wait_q     <= 1'b0;
		end else if (step) begin
			a_prev_q       <= quadrature_a;
			btn_prev_q     <= button_level;
			press_time_q   <= press_time_d;
			release_time_q <= release_time_d;
			ignore_rel_q   <= ignore_rel_d;
			single_ok_q    <= single_ok_d;
			hold_rep_q     <= hold_rep_d;
			long_rep_q     <= long_rep_d;
			dbl_on_rel_q   <= dbl_on_rel_d;
			dbl_wait_q     <= dbl_wait_d;
		end
	end

endmodule

// File: rtl/ebed_checker.sv
`timescale 1ns / 1ps

module ebed_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [1:0] rotation,
	input logic [2:0] button_event,
	input logic       pready
);

	// A stalled result stays on the port unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(rotation) &&
		$stable(button_event))
		else $error("stalled result changed");

	// Only the three rotation codes ever leave the block.
	a_rotation_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> rotation <= ebed_pkg::ROT_CW)
		else $error("rotation code out of range");

	// Button events stay within none to long hold.
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> button_event <= ebed_pkg::EV_LONG_HOLD)
		else $error("button event code out of range");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind encoder_and_button_event_detector_unit ebed_checker u_ebed_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.rotation     (rotation),
	.button_event (button_event),
	.pready       (pready)
);
